@@ rtl/core/erm_pkg.sv @@
// Shared constants, types and arithmetic helpers of the rotation matrix block.
package erm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IFRAC         = 30;
  localparam int CORDIC_N      = 30;
  localparam int CORDIC_STEPS  = 3;
  localparam int CORDIC_CYC    = CORDIC_N / CORDIC_STEPS;
  localparam int QW            = 35;   // angle in Q.30, wide enough for +-8 rad
  localparam int CW            = 34;   // CORDIC datapath
  localparam int EW            = 32;   // matrix element, Q.30 within +-1.0
  localparam int QDEPTH        = 2;
  localparam int CFG_IW        = 2;

  localparam logic [CFG_IW-1:0] REG_PRODUCT_ORDER = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SIGN_CONV     = 2'd1;

  localparam logic [1:0] KIND_ROT    = 2'd0;
  localparam logic [1:0] KIND_DOMEGA = 2'd1;
  localparam logic [1:0] KIND_DPHI   = 2'd2;
  localparam logic [1:0] KIND_DKAPPA = 2'd3;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef logic signed [QW-1:0] angq_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t [2:0] row_t;
  typedef row_t  [2:0] mat_t;

  localparam angq_t PI_Q      = 35'sd3373259426;
  localparam angq_t TWO_PI_Q  = 35'sd6746518853;
  localparam angq_t HALF_PI_Q = 35'sd1686629713;
  localparam cval_t GAIN_Q    = 34'sd652032874;
  localparam cval_t ONE_C     = 34'sd1073741824;
  localparam elem_t ONE_E     = 32'sd1073741824;

  typedef struct packed {
    angq_t omega;
    angq_t phi;
    angq_t kappa;
    logic  batch;
  } item_t;

  typedef struct packed {
    elem_t c;
    elem_t s;
  } sc_t;

  typedef struct packed {
    sc_t  x;
    sc_t  y;
    sc_t  z;
    logic batch;
  } trig_t;

  typedef struct packed {
    logic product_order;
    logic sign_convention;
  } cfg_t;

  function automatic cval_t atan_q(input logic [4:0] i);
    cval_t v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic elem_t sat_c(input cval_t v);
    elem_t r;
    if (v > ONE_C) r = ONE_E;
    else if (v < -ONE_C) r = -ONE_E;
    else r = v[EW-1:0];
    return r;
  endfunction

  // sum of three Q.60 terms, round half up to Q.30, clamp to +-1.0
  function automatic elem_t dot3(input row_t a, input row_t b);
    logic signed [63:0] p0, p1, p2;
    logic signed [65:0] s;
    logic signed [65:0] t;
    elem_t r;
    p0 = a[0] * b[0];
    p1 = a[1] * b[1];
    p2 = a[2] * b[2];
    s  = p0 + p1 + p2;
    t  = (s + 66'sd536870912) >>> IFRAC;
    if (t > 66'sd1073741824) r = ONE_E;
    else if (t < -66'sd1073741824) r = -ONE_E;
    else r = t[EW-1:0];
    return r;
  endfunction

  function automatic row_t mat_col(input mat_t m, input logic [1:0] j);
    row_t r;
    r[0] = m[0][j];
    r[1] = m[1][j];
    r[2] = m[2][j];
    return r;
  endfunction

  // single-axis rotation (or its derivative), optionally transposed
  function automatic mat_t axis_mat(input logic [1:0] axis, input elem_t c, input elem_t s,
                                    input logic deriv, input logic transp);
    mat_t m;
    logic [1:0] p, q;
    elem_t dg, off, up, lo;
    m   = '0;
    p   = (axis == AX_X) ? 2'd1 : 2'd0;
    q   = (axis == AX_Z) ? 2'd1 : 2'd2;
    dg  = deriv ? -s : c;
    off = deriv ? c : s;
    up  = (axis == AX_Y) ? off : -off;
    lo  = (axis == AX_Y) ? -off : off;
    if (!deriv) m[axis][axis] = ONE_E;
    m[p][p] = dg;
    m[q][q] = dg;
    if (transp) begin
      m[p][q] = lo;
      m[q][p] = up;
    end else begin
      m[p][q] = up;
      m[q][p] = lo;
    end
    return m;
  endfunction

endpackage

@@ rtl/core/erm_ifs.sv @@
// Channel interfaces: angle input, row result and register write.
interface erm_in_if #(parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+3:0] omega_angle;
  logic signed [FRAC_BITS+3:0] phi_angle;
  logic signed [FRAC_BITS+3:0] kappa_angle;
  logic                        batch_end;
  modport source (output valid, omega_angle, phi_angle, kappa_angle, batch_end, input ready);
  modport sink   (input valid, omega_angle, phi_angle, kappa_angle, batch_end, output ready);
endinterface

interface erm_out_if #(parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  matrix_kind;
  logic [1:0]                  row_number;
  logic signed [FRAC_BITS+1:0] elem_col0;
  logic signed [FRAC_BITS+1:0] elem_col1;
  logic signed [FRAC_BITS+1:0] elem_col2;
  logic                        last_of_item;
  logic                        batch_done;
  modport source (output valid, matrix_kind, row_number, elem_col0, elem_col1, elem_col2,
                  last_of_item, batch_done, input ready);
  modport sink   (input valid, matrix_kind, row_number, elem_col0, elem_col1, elem_col2,
                  last_of_item, batch_done, output ready);
endinterface

interface erm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [erm_pkg::CFG_IW-1:0]    reg_index;
  logic                          wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/core/erm_front.sv @@
// Front end: takes angle words, scales them to Q.30 and wraps into [-pi, pi].
module erm_front #(
  parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  erm_in_if.sink          in_chan,
  output logic            q_valid,
  input  logic            q_ready,
  output erm_pkg::item_t  q_item
);

  localparam int SH = erm_pkg::IFRAC - FRAC_BITS;

  logic           valid_r;
  erm_pkg::item_t item_r, item_nxt;

  function automatic erm_pkg::angq_t wrap(input logic signed [FRAC_BITS+3:0] raw);
    erm_pkg::angq_t a;
    a = erm_pkg::angq_t'(raw) <<< SH;
    if (a > erm_pkg::PI_Q) a = a - erm_pkg::TWO_PI_Q;
    else if (a < -erm_pkg::PI_Q) a = a + erm_pkg::TWO_PI_Q;
    return a;
  endfunction

  assign in_chan.ready = !valid_r || q_ready;

  always_comb begin
    item_nxt.omega = wrap(in_chan.omega_angle);
    item_nxt.phi   = wrap(in_chan.phi_angle);
    item_nxt.kappa = wrap(in_chan.kappa_angle);
    item_nxt.batch = in_chan.batch_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

@@ rtl/core/erm_queue.sv @@
// Short word queue between the front end and the CORDIC back end.
module erm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  erm_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output erm_pkg::item_t  rd_item
);

  localparam int AW = (erm_pkg::QDEPTH > 1) ? $clog2(erm_pkg::QDEPTH) : 1;
  localparam int NW = $clog2(erm_pkg::QDEPTH + 1);

  erm_pkg::item_t  ent_r [erm_pkg::QDEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [NW-1:0]   cnt_r;
  logic            push, pop;

  assign wr_ready = cnt_r < NW'(erm_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(erm_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(erm_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + NW'(push) - NW'(pop);
    end
    if (push) ent_r[wp_r] <= wr_item;
  end

endmodule

@@ rtl/core/erm_cordic.sv @@
// Three-lane CORDIC, three micro-rotations per cycle, for sin/cos of each angle.
module erm_cordic (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  erm_pkg::item_t  in_item,
  output logic            trig_valid,
  input  logic            trig_ready,
  output erm_pkg::trig_t  trig
);

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_RUN  = 3'b010,
    CS_DONE = 3'b100
  } cs_t;

  cs_t                state_r;
  erm_pkg::cval_t     x_r [3], y_r [3], z_r [3];
  erm_pkg::cval_t     x_nxt [3], y_nxt [3], z_nxt [3];
  logic [2:0]         neg_r, neg_nxt;
  logic [4:0]         base_r;
  logic [3:0]         it_r;
  logic               batch_r;
  erm_pkg::angq_t     ang [3];
  erm_pkg::elem_t     co [3], si [3];

  assign ang[0] = in_item.omega;
  assign ang[1] = in_item.phi;
  assign ang[2] = in_item.kappa;

  assign in_ready   = state_r == CS_IDLE;
  assign trig_valid = state_r == CS_DONE;

  always_comb begin
    erm_pkg::cval_t xa, ya, za, xt;
    erm_pkg::angq_t a;
    logic [4:0] idx;
    for (int l = 0; l < 3; l++) begin
      // load: fold into [-pi/2, pi/2], remembering a sign flip
      a = ang[l];
      neg_nxt[l] = 1'b0;
      if (a > erm_pkg::HALF_PI_Q) begin
        a = a - erm_pkg::PI_Q;
        neg_nxt[l] = 1'b1;
      end else if (a < -erm_pkg::HALF_PI_Q) begin
        a = a + erm_pkg::PI_Q;
        neg_nxt[l] = 1'b1;
      end
      xa = x_r[l];
      ya = y_r[l];
      za = z_r[l];
      for (int j = 0; j < erm_pkg::CORDIC_STEPS; j++) begin
        idx = base_r + 5'(j);
        if (za >= 0) begin
          xt = xa - (ya >>> idx);
          ya = ya + (xa >>> idx);
          za = za - erm_pkg::atan_q(idx);
        end else begin
          xt = xa + (ya >>> idx);
          ya = ya - (xa >>> idx);
          za = za + erm_pkg::atan_q(idx);
        end
        xa = xt;
      end
      if (state_r == CS_IDLE) begin
        x_nxt[l] = erm_pkg::GAIN_Q;
        y_nxt[l] = '0;
        z_nxt[l] = a[erm_pkg::CW-1:0];
      end else begin
        x_nxt[l] = xa;
        y_nxt[l] = ya;
        z_nxt[l] = za;
      end
      co[l] = erm_pkg::sat_c(neg_r[l] ? -x_r[l] : x_r[l]);
      si[l] = erm_pkg::sat_c(neg_r[l] ? -y_r[l] : y_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      it_r    <= '0;
      base_r  <= '0;
    end else begin
      case (state_r)
        CS_IDLE: begin
          if (in_valid) begin
            state_r <= CS_RUN;
            it_r    <= '0;
            base_r  <= '0;
          end
        end
        CS_RUN: begin
          it_r   <= it_r + 1'b1;
          base_r <= base_r + 5'(erm_pkg::CORDIC_STEPS);
          if (it_r == 4'(erm_pkg::CORDIC_CYC - 1)) state_r <= CS_DONE;
        end
        CS_DONE: begin
          if (trig_ready) state_r <= CS_IDLE;
        end
        default: state_r <= CS_IDLE;
      endcase
    end
    if ((state_r == CS_IDLE && in_valid) || state_r == CS_RUN) begin
      for (int l = 0; l < 3; l++) begin
        x_r[l] <= x_nxt[l];
        y_r[l] <= y_nxt[l];
        z_r[l] <= z_nxt[l];
      end
    end
    if (state_r == CS_IDLE && in_valid) begin
      neg_r   <= neg_nxt;
      batch_r <= in_item.batch;
    end
  end

  assign trig.x.c  = co[0];
  assign trig.x.s  = si[0];
  assign trig.y.c  = co[1];
  assign trig.y.s  = si[1];
  assign trig.z.c  = co[2];
  assign trig.z.s  = si[2];
  assign trig.batch = batch_r;

endmodule

@@ rtl/core/erm_rows.sv @@
// Row sequencer and two-stage matrix product pipeline feeding the result register.
module erm_rows #(
  parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  erm_pkg::cfg_t   cfg,
  input  logic            trig_valid,
  output logic            trig_ready,
  input  erm_pkg::trig_t  trig,
  erm_out_if.source       out_chan
);

  localparam int OW = FRAC_BITS + 2;
  localparam int SH = erm_pkg::IFRAC - FRAC_BITS;
  localparam logic signed [erm_pkg::EW:0] HALF = (erm_pkg::EW + 1)'((64'sd1 << SH) >>> 1);
  localparam logic signed [erm_pkg::EW:0] LIM  = (erm_pkg::EW + 1)'(64'sd1 << FRAC_BITS);

  erm_pkg::trig_t  bank_r;
  logic            bank_valid_r;
  logic [1:0]      kind_r, row_r;
  logic            advance, issue, last_issue, load;
  erm_pkg::mat_t   rx, ry, rz, dx, dy, dz, ma, mb, mc;
  erm_pkg::row_t   t_nxt, r_nxt;

  logic            s1_valid_r, s2_valid_r, out_valid_r;
  erm_pkg::row_t   t_r, r2_r;
  erm_pkg::mat_t   c_r;
  logic [1:0]      s1_kind_r, s1_row_r, s2_kind_r, s2_row_r;
  logic            s1_last_r, s1_batch_r, s2_last_r, s2_batch_r;
  logic [1:0]      o_kind_r, o_row_r;
  logic            o_last_r, o_batch_r;
  logic signed [OW-1:0] o_col_r [3];
  logic signed [OW-1:0] o_col_nxt [3];

  assign advance    = !out_valid_r || out_chan.ready;
  assign issue      = bank_valid_r && advance;
  assign last_issue = issue && kind_r == erm_pkg::KIND_DKAPPA && row_r == erm_pkg::LAST_ROW;
  assign trig_ready = !bank_valid_r || last_issue;
  assign load       = trig_valid && trig_ready;

  always_comb begin
    rx = erm_pkg::axis_mat(erm_pkg::AX_X, bank_r.x.c, bank_r.x.s, 1'b0, cfg.sign_convention);
    dx = erm_pkg::axis_mat(erm_pkg::AX_X, bank_r.x.c, bank_r.x.s, 1'b1, cfg.sign_convention);
    ry = erm_pkg::axis_mat(erm_pkg::AX_Y, bank_r.y.c, bank_r.y.s, 1'b0, cfg.sign_convention);
    dy = erm_pkg::axis_mat(erm_pkg::AX_Y, bank_r.y.c, bank_r.y.s, 1'b1, cfg.sign_convention);
    rz = erm_pkg::axis_mat(erm_pkg::AX_Z, bank_r.z.c, bank_r.z.s, 1'b0, cfg.sign_convention);
    dz = erm_pkg::axis_mat(erm_pkg::AX_Z, bank_r.z.c, bank_r.z.s, 1'b1, cfg.sign_convention);
    // the partial swaps its own factor for the derivative matrix
    ma = cfg.product_order ? rz : rx;
    mb = ry;
    mc = cfg.product_order ? rx : rz;
    case (kind_r)
      erm_pkg::KIND_ROT: begin
      end
      erm_pkg::KIND_DOMEGA: begin
        if (cfg.product_order) mc = dx;
        else ma = dx;
      end
      erm_pkg::KIND_DPHI: mb = dy;
      erm_pkg::KIND_DKAPPA: begin
        if (cfg.product_order) ma = dz;
        else mc = dz;
      end
      default: begin
      end
    endcase
    for (int j = 0; j < 3; j++) begin
      t_nxt[j] = erm_pkg::dot3(ma[row_r], erm_pkg::mat_col(mb, 2'(j)));
      r_nxt[j] = erm_pkg::dot3(t_r, erm_pkg::mat_col(c_r, 2'(j)));
    end
  end

  always_comb begin
    logic signed [erm_pkg::EW:0] v;
    for (int j = 0; j < 3; j++) begin
      v = ((erm_pkg::EW + 1)'(r2_r[j]) + HALF) >>> SH;
      if (v > LIM) v = LIM;
      else if (v < -LIM) v = -LIM;
      o_col_nxt[j] = v[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_valid_r <= 1'b0;
      kind_r       <= erm_pkg::KIND_ROT;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load) bank_valid_r <= 1'b1;
      else if (last_issue) bank_valid_r <= 1'b0;
      if (issue) begin
        if (row_r == erm_pkg::LAST_ROW) begin
          row_r  <= '0;
          kind_r <= kind_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end
      if (advance) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
    if (load) bank_r <= trig;
    if (advance) begin
      t_r        <= t_nxt;
      c_r        <= mc;
      s1_kind_r  <= kind_r;
      s1_row_r   <= row_r;
      s1_last_r  <= kind_r == erm_pkg::KIND_DKAPPA && row_r == erm_pkg::LAST_ROW;
      s1_batch_r <= bank_r.batch;
      r2_r       <= r_nxt;
      s2_kind_r  <= s1_kind_r;
      s2_row_r   <= s1_row_r;
      s2_last_r  <= s1_last_r;
      s2_batch_r <= s1_batch_r;
      o_kind_r   <= s2_kind_r;
      o_row_r    <= s2_row_r;
      o_last_r   <= s2_last_r;
      o_batch_r  <= s2_batch_r && s2_last_r;
      for (int j = 0; j < 3; j++) o_col_r[j] <= o_col_nxt[j];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.matrix_kind  = o_kind_r;
  assign out_chan.row_number   = o_row_r;
  assign out_chan.elem_col0    = o_col_r[0];
  assign out_chan.elem_col1    = o_col_r[1];
  assign out_chan.elem_col2    = o_col_r[2];
  assign out_chan.last_of_item = o_last_r;
  assign out_chan.batch_done   = o_batch_r;

  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_last_r == (o_kind_r == erm_pkg::KIND_DKAPPA &&
                                  o_row_r == erm_pkg::LAST_ROW)))
    else $error("last flag does not match final row");

  a_batch_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_batch_r |-> o_last_r)
    else $error("batch flag away from final row");

  a_bank_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(bank_valid_r) |-> $past(last_issue))
    else $error("bank released before all rows issued");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(s2_valid_r) && $stable(s1_valid_r))
    else $error("pipeline moved during stall");

endmodule

@@ rtl/core/euler_rotation_matrix_and_partials_core.sv @@
// Top level: omega-phi-kappa rotation matrix and its three angle partials.
//
// Usage
//   in_chan  : one word per image, three Q3.16 angles (omega, phi, kappa) and
//              a batch_end flag. Accepted when valid and ready are both high.
//   out_chan : twelve words per input word, rotation matrix then d/domega,
//              d/dphi, d/dkappa, rows 0..2 each, Q1.16 clamped to +-1.0.
//              last_of_item marks the twelfth; batch_done echoes batch_end there.
//   cfg_chan : register writes, index 0 product_order, 1 sign_convention;
//              other indexes are dropped. Always ready; write only while idle.
// Structure
//   Front register, 2-entry queue, CORDIC, then a 3-register product pipe.
//   The word rate is bounded both by the 12 result rows and by the CORDIC
//   loop (load, iterations of 3 micro-rotations, hand-off), which takes no new
//   word until the last one has been handed off.
// Reset
//   rst_n (sync, active low) empties all stages and clears both registers.
// Back-pressure
//   A stalled out_chan freezes the product pipe; the CORDIC finishes and holds
//   its result, and the front takes words until queue and front register fill.
module euler_rotation_matrix_and_partials_core #(
  parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  erm_in_if.sink     in_chan,
  erm_out_if.source  out_chan,
  erm_cfg_if.sink    cfg_chan
);

  logic            fq_valid, fq_ready, qc_valid, qc_ready, tr_valid, tr_ready;
  erm_pkg::item_t  fq_item, qc_item;
  erm_pkg::trig_t  tr;
  erm_pkg::cfg_t   cfg_r;

  assign cfg_chan.ready = 1'b1;

  // register file; each register keeps the one-bit write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        erm_pkg::REG_PRODUCT_ORDER: cfg_r.product_order   <= cfg_chan.wr_data;
        erm_pkg::REG_SIGN_CONV:     cfg_r.sign_convention <= cfg_chan.wr_data;
        default: begin
        end
      endcase
    end
  end

  erm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  erm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qc_valid),
    .rd_ready (qc_ready),
    .rd_item  (qc_item)
  );

  erm_cordic u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (qc_valid),
    .in_ready   (qc_ready),
    .in_item    (qc_item),
    .trig_valid (tr_valid),
    .trig_ready (tr_ready),
    .trig       (tr)
  );

  erm_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .trig_valid (tr_valid),
    .trig_ready (tr_ready),
    .trig       (tr),
    .out_chan   (out_chan)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for the omega-phi-kappa rotation matrix and partials core.
`timescale 1ns / 1ps

module tb;

  localparam int FB = 16;
  localparam int AW = FB + 4;
  localparam int OW = FB + 2;
  localparam int QUIET_LIMIT = 3000;   // cycles with no handshake before giving up
  localparam int DRAIN_CYC = 40;       // idle cycles added once every row is out
  localparam logic [erm_pkg::CFG_IW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [erm_pkg::CFG_IW-1:0] REG_SPARE_B = 2'd3;

  localparam longint ONE30 = 64'sd1073741824;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint TWO_PI30 = 64'sd6746518853;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam longint GAIN30 = 64'sd652032874;
  localparam int HALF_PI16 = 102944;   // pi/2 in Q3.16
  localparam int PI16 = 205887;        // pi in Q3.16

  typedef longint m3_t [3][3];

  typedef struct {
    logic signed [AW-1:0] omega;
    logic signed [AW-1:0] phi;
    logic signed [AW-1:0] kappa;
    logic batch_end;
  } angles_t;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] row;
    logic signed [OW-1:0] col [3];
    logic last;
    logic batch;
  } row_word_t;

  const longint arctan_q30 [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  erm_in_if #(.FRAC_BITS(FB)) in_if ();
  erm_out_if #(.FRAC_BITS(FB)) out_if ();
  erm_cfg_if cfg_if ();

  euler_rotation_matrix_and_partials_core #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if.sink), .out_chan(out_if.source),
    .cfg_chan(cfg_if.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the two registers
  logic order_cfg = 1'b0;
  logic transp_cfg = 1'b0;

  angles_t angle_queue [$];
  row_word_t rows_due [$];
  bit fail = 1'b0;
  bit burst_mode = 1'b0;   // no idling on either side while set

  // ---------------- predictor ----------------
  function automatic longint clamp1(longint v);
    return v > ONE30 ? ONE30 : (v < -ONE30 ? -ONE30 : v);
  endfunction

  // 30-step CORDIC with quadrant fold, Q.30
  function automatic void cordic_sc(longint a, output longint co, output longint si);
    longint x, y, t;
    bit flip;
    x = GAIN30;
    y = 0;
    flip = 0;
    while (a > PI30) a -= TWO_PI30;
    while (a < -PI30) a += TWO_PI30;
    if (a > HALF_PI30) begin
      a -= PI30;
      flip = 1;
    end else if (a < -HALF_PI30) begin
      a += PI30;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a -= arctan_q30[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a += arctan_q30[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    co = clamp1(x);
    si = clamp1(y);
  endfunction

  // single-axis matrix (or derivative), transposed on request
  function automatic m3_t axis_rot(int ax, longint c, longint s, bit deriv, bit tr);
    m3_t m;
    int p, q;
    longint sg, up, lo;
    p = (ax == 0) ? 1 : 0;
    q = (ax == 2) ? 1 : 2;
    sg = (ax == 1) ? -1 : 1;
    foreach (m[i, j]) m[i][j] = 0;
    if (!deriv) m[ax][ax] = ONE30;
    m[p][p] = deriv ? -s : c;
    m[q][q] = deriv ? -s : c;
    up = deriv ? -sg * c : -sg * s;
    lo = deriv ? sg * c : sg * s;
    m[p][q] = tr ? lo : up;
    m[q][p] = tr ? up : lo;
    return m;
  endfunction

  function automatic m3_t mat_mul(m3_t a, m3_t b);
    m3_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = clamp1((acc + (ONE30 >>> 1)) >>> 30);
      end
    return r;
  endfunction

  function automatic logic signed [OW-1:0] to_q16(longint v);
    longint r;
    r = (v + (64'sd1 <<< 13)) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r[OW-1:0];
  endfunction

  // all twelve rows of one angle word go onto rows_due
  function automatic void predict_rows(angles_t w);
    m3_t r [3];
    m3_t d [3];
    m3_t res [4];
    longint c, s;
    longint ang [3];
    row_word_t e;
    ang[0] = longint'(w.omega) * 16384;
    ang[1] = longint'(w.phi) * 16384;
    ang[2] = longint'(w.kappa) * 16384;
    for (int ax = 0; ax < 3; ax++) begin
      cordic_sc(ang[ax], c, s);
      r[ax] = axis_rot(ax, c, s, 0, transp_cfg);
      d[ax] = axis_rot(ax, c, s, 1, transp_cfg);
    end
    if (!order_cfg) begin
      res[erm_pkg::KIND_ROT] = mat_mul(mat_mul(r[0], r[1]), r[2]);
      res[erm_pkg::KIND_DOMEGA] = mat_mul(mat_mul(d[0], r[1]), r[2]);
      res[erm_pkg::KIND_DPHI] = mat_mul(mat_mul(r[0], d[1]), r[2]);
      res[erm_pkg::KIND_DKAPPA] = mat_mul(mat_mul(r[0], r[1]), d[2]);
    end else begin
      res[erm_pkg::KIND_ROT] = mat_mul(mat_mul(r[2], r[1]), r[0]);
      res[erm_pkg::KIND_DOMEGA] = mat_mul(mat_mul(r[2], r[1]), d[0]);
      res[erm_pkg::KIND_DPHI] = mat_mul(mat_mul(r[2], d[1]), r[0]);
      res[erm_pkg::KIND_DKAPPA] = mat_mul(mat_mul(d[2], r[1]), r[0]);
    end
    for (int k = 0; k < 4; k++)
      for (int rw = 0; rw < 3; rw++) begin
        e.kind = k[1:0];
        e.row = rw[1:0];
        for (int j = 0; j < 3; j++) e.col[j] = to_q16(res[k][rw][j]);
        e.last = (k == 3 && rw == 2);
        e.batch = e.last ? w.batch_end : 1'b0;
        rows_due.insert(rows_due.size(), e);
      end
  endfunction

  // ---------------- input driver ----------------
  bit in_taken = 0;
  bit in_busy = 0;
  int in_gap = 0;
  int quiet = 0;

  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 17);
  endfunction

  always @(negedge clk) begin
    logic v_next;
    v_next = in_if.valid;
    if (rst_n) begin
      if (in_taken) begin
        in_busy = 0;
        in_taken = 0;
        v_next = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          v_next = 1'b0;
        end else if (angle_queue.size() > 0) begin
          angles_t w;
          w = angle_queue.pop_front();
          in_if.omega_angle <= w.omega;
          in_if.phi_angle <= w.phi;
          in_if.kappa_angle <= w.kappa;
          in_if.batch_end <= w.batch_end;
          v_next = 1'b1;
          in_busy = 1;
          in_gap = draw_wait();
        end else begin
          v_next = 1'b0;
        end
      end
    end
    in_if.valid <= v_next;
  end

  // ---------------- output stall ----------------
  bit out_taken = 0;
  int out_stall = 0;

  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 0;
      out_stall = draw_wait();
    end
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------- monitor, scoreboard, watchdog ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (in_if.valid && in_if.ready) begin
        angles_t w;
        w.omega = in_if.omega_angle;
        w.phi = in_if.phi_angle;
        w.kappa = in_if.kappa_angle;
        w.batch_end = in_if.batch_end;
        predict_rows(w);
        in_taken = 1;
        quiet = 0;
      end
      if (cfg_if.valid && cfg_if.ready) quiet = 0;
      if (out_if.valid && out_if.ready) begin
        row_word_t e;
        logic signed [OW-1:0] got [3];
        out_taken = 1;
        quiet = 0;
        got[0] = out_if.elem_col0;
        got[1] = out_if.elem_col1;
        got[2] = out_if.elem_col2;
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row word kind=%0d row=%0d", $time,
                   out_if.matrix_kind, out_if.row_number);
          fail = 1;
        end else begin
          e = rows_due.pop_front();
          if (out_if.matrix_kind !== e.kind) begin
            $display("%0t: matrix_kind exp %0d got %0d", $time, e.kind, out_if.matrix_kind);
            fail = 1;
          end
          if (out_if.row_number !== e.row) begin
            $display("%0t: row_number exp %0d got %0d", $time, e.row, out_if.row_number);
            fail = 1;
          end
          for (int j = 0; j < 3; j++)
            if (got[j] !== e.col[j]) begin
              $display("%0t: kind %0d row %0d col%0d exp %0d got %0d", $time, e.kind,
                       e.row, j, e.col[j], got[j]);
              fail = 1;
            end
          if (out_if.last_of_item !== e.last) begin
            $display("%0t: last_of_item exp %0b got %0b", $time, e.last, out_if.last_of_item);
            fail = 1;
          end
          if (out_if.batch_done !== e.batch) begin
            $display("%0t: batch_done exp %0b got %0b", $time, e.batch, out_if.batch_done);
            fail = 1;
          end
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [AW-1:0] rand_angle();
    int sel;
    int a;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: a = int'($urandom);                       // full field, wraps
      3, 4, 5, 6: a = $urandom_range(0, 2 * PI16) - PI16;  // principal range
      7: a = ($urandom_range(0, 1) ? HALF_PI16 : -HALF_PI16) + $urandom_range(0, 6) - 3;
      8: a = ($urandom_range(0, 1) ? PI16 : -PI16) + $urandom_range(0, 6) - 3;
      default: a = $urandom_range(0, 64) - 32;            // near zero
    endcase
    return a[AW-1:0];
  endfunction

  task automatic queue_angles(int om, int ph, int ka, bit be);
    angles_t w;
    w.omega = om[AW-1:0];
    w.phi = ph[AW-1:0];
    w.kappa = ka[AW-1:0];
    w.batch_end = be;
    angle_queue.insert(angle_queue.size(), w);
  endtask

  task automatic write_reg(logic [erm_pkg::CFG_IW-1:0] idx, logic val);
    @(negedge clk);
    cfg_if.reg_index <= idx;
    cfg_if.wr_data <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == erm_pkg::REG_PRODUCT_ORDER) order_cfg = val;
    else if (idx == erm_pkg::REG_SIGN_CONV) transp_cfg = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every queued word is in and every row is out, then let the pipe drain
  task automatic drain();
    while (angle_queue.size() > 0 || in_busy || rows_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.omega_angle = '0;
    in_if.phi_angle = '0;
    in_if.kappa_angle = '0;
    in_if.batch_end = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = erm_pkg::REG_PRODUCT_ORDER;
    cfg_if.wr_data = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) drain();
      write_reg(erm_pkg::REG_PRODUCT_ORDER, ph[0]);
      write_reg(erm_pkg::REG_SIGN_CONV, ph[1]);
      if (ph == 2) begin
        // spare indexes must not touch either register
        write_reg(REG_SPARE_A, 1'b1);
        write_reg(REG_SPARE_B, 1'b1);
      end
      burst_mode = (ph == 3);
      if (ph == 0) begin
        // zero, field extremes, quadrant edges, +-pi, batch flag
        queue_angles(0, 0, 0, 0);
        queue_angles(524287, 524287, 524287, 1);
        queue_angles(-524288, -524288, -524288, 0);
        queue_angles(524287, -524288, 0, 1);
        queue_angles(HALF_PI16, HALF_PI16 + 1, HALF_PI16 - 1, 0);
        queue_angles(-HALF_PI16, -HALF_PI16 - 1, -HALF_PI16 + 1, 0);
        queue_angles(PI16, -PI16, PI16 + 1, 1);
        queue_angles(-PI16 - 1, PI16 - 1, -PI16 + 1, 0);
        queue_angles(2 * PI16, -2 * PI16, 3 * PI16, 0);
        queue_angles(1, -1, 1, 1);
        queue_angles(HALF_PI16, 0, 0, 0);
        queue_angles(0, HALF_PI16, 0, 0);
        queue_angles(0, 0, HALF_PI16, 1);
        queue_angles(21845, 349525, -349526, 0);
      end
      for (int n = 0; n < 38; n++)
        queue_angles(rand_angle(), rand_angle(), rand_angle(), $urandom_range(0, 1));
    end

    drain();
    if (!fail)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/erm_pkg.sv
rtl/core/erm_ifs.sv
rtl/core/erm_front.sv
rtl/core/erm_queue.sv
rtl/core/erm_cordic.sv
rtl/core/erm_rows.sv
rtl/core/euler_rotation_matrix_and_partials_core.sv
tb/tb.sv
